>>> sv/wav_sample_normalizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample normalizer
// Immediate-implication and next-cycle forms, clocked on clk and disabled
// while arst_n is low. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WAV_SAMPLE_NORMALIZER_ASSERT_SVH
`define WAV_SAMPLE_NORMALIZER_ASSERT_SVH
`ifndef SYNTH
`define WSN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsn assertion failed");
`define WSN_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsn assertion failed");
`else
`define WSN_ASSERT_IMP(label, ante, cons)
`define WSN_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> sv/wsn_pkg.sv
// ----------------------------------------------------------------------------
// Sample normalizer package
// Widths, register and format codes, the configuration struct and the
// G.711 decode tables, which are built at elaboration.
// ----------------------------------------------------------------------------
package wsn_pkg;

	localparam int unsigned IDX_W      = 32;
	localparam int unsigned CH_W       = 16;
	localparam int unsigned RAW_W      = 64;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned FMT_W      = 2;
	localparam int unsigned BPS_W      = 7;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [FMT_W-1:0] FMT_PCM   = 2'd0;
	localparam logic [FMT_W-1:0] FMT_FLOAT = 2'd1;
	localparam logic [FMT_W-1:0] FMT_MULAW = 2'd2;
	localparam logic [FMT_W-1:0] FMT_ALAW  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 2'd3;

	localparam logic [BPS_W-1:0] BPS_RESET      = 7'd16;
	localparam logic [CH_W-1:0]  CHANNELS_RESET = 16'd1;

	localparam logic [VAL_W-1:0] Q31_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] Q31_NEG_MAX = 32'h8000_0000;

	localparam longint unsigned MuFullScale = 64'd8031;
	localparam longint unsigned AFullScale  = 64'd4032;

	typedef struct packed {
		logic [FMT_W-1:0] format;
		logic [BPS_W-1:0] bps;
		logic [CH_W-1:0]  chan_count;
		logic [IDX_W-1:0] samp_count;
	} cfg_t;

	typedef logic [VAL_W-1:0] g711_tab_t [256];

	function automatic logic [VAL_W-1:0] g711_word(logic neg, longint unsigned scaled);
		logic [63:0] negated;
		negated = 64'd0 - scaled;
		if (neg) begin
			return (scaled > 64'h8000_0000) ? Q31_NEG_MAX : negated[VAL_W-1:0];
		end
		return (scaled > 64'h7FFF_FFFF) ? Q31_POS_MAX : scaled[VAL_W-1:0];
	endfunction

	// Restoring long division, only evaluated while the tables are built.
	function automatic longint unsigned const_div(longint unsigned num,
		longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 1) | {63'd0, num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Mu-law codes are stored inverted on the line.
	function automatic g711_tab_t build_mu_tab();
		g711_tab_t tab;
		logic [7:0] b;
		longint unsigned mag;
		longint unsigned scaled;
		for (int c = 0; c < 256; c++) begin
			b = ~8'(c);
			mag = ((64'({1'b1, b[3:0]}) << 1) | 64'd1) << b[6:4];
			mag = mag - 64'd33;
			scaled = const_div((mag << 32) + MuFullScale, 2 * MuFullScale);
			tab[c] = g711_word(b[7], scaled);
		end
		return tab;
	endfunction

	// A-law codes have their even bits inverted on the line.
	function automatic g711_tab_t build_a_tab();
		g711_tab_t tab;
		logic [7:0] b;
		longint unsigned mag;
		longint unsigned scaled;
		for (int c = 0; c < 256; c++) begin
			b = 8'(c) ^ 8'h55;
			mag = (64'({b[6:4] != 3'd0, b[3:0]}) << 1) | 64'd1;
			if (b[6:4] != 3'd0) begin
				mag = mag << (b[6:4] - 3'd1);
			end
			scaled = const_div((mag << 32) + AFullScale, 2 * AFullScale);
			tab[c] = g711_word(~b[7], scaled);
		end
		return tab;
	endfunction

	localparam g711_tab_t MU_TAB = build_mu_tab();
	localparam g711_tab_t A_TAB  = build_a_tab();

endpackage

>>> sv/wsn_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one raw sample request per transfer.
// ----------------------------------------------------------------------------
interface wsn_sample_if;
	logic                       valid;
	logic                       ready;
	logic [wsn_pkg::IDX_W-1:0]  sample_index;
	logic [wsn_pkg::CH_W-1:0]   channel;
	logic [wsn_pkg::RAW_W-1:0]  raw_sample;

	modport source (output valid, sample_index, channel, raw_sample, input ready);
	modport sink   (input valid, sample_index, channel, raw_sample, output ready);
endinterface

>>> sv/wsn_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one normalized sample per transfer.
// ----------------------------------------------------------------------------
interface wsn_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [wsn_pkg::VAL_W-1:0] sample_value;
	logic                             invalid;
	logic                             clipped;

	modport source (output valid, sample_value, invalid, clipped, input ready);
	modport sink   (input valid, sample_value, invalid, clipped, output ready);
endinterface

>>> sv/wsn_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds format, sample width, channel count and frame count, written
// through a plain indexed write port.
// ----------------------------------------------------------------------------
module wsn_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [wsn_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [wsn_pkg::CFG_DATA_W-1:0]    wr_data,
	output wsn_pkg::cfg_t                     cfg
);

	wsn_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.format     <= wsn_pkg::FMT_PCM;
			cfg_q.bps        <= wsn_pkg::BPS_RESET;
			cfg_q.chan_count <= wsn_pkg::CHANNELS_RESET;
			cfg_q.samp_count <= '0;
		end else if (wr_en) begin
			case (wr_index)
				wsn_pkg::REG_FORMAT:   cfg_q.format     <= wr_data[wsn_pkg::FMT_W-1:0];
				wsn_pkg::REG_BPS:      cfg_q.bps        <= wr_data[wsn_pkg::BPS_W-1:0];
				wsn_pkg::REG_CHANNELS: cfg_q.chan_count <= wr_data[wsn_pkg::CH_W-1:0];
				wsn_pkg::REG_SAMPLES:  cfg_q.samp_count <= wr_data[wsn_pkg::IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/wsn_decode.sv
// ----------------------------------------------------------------------------
// Sample decode
// Bounds check and format decode of one sample to a rounded, saturated
// Q1.31 word, with invalid and clip flags.
// ----------------------------------------------------------------------------
module wsn_decode (
	input  wsn_pkg::cfg_t                     cfg,
	input  logic [wsn_pkg::IDX_W-1:0]         sample_index,
	input  logic [wsn_pkg::CH_W-1:0]          channel,
	input  logic [wsn_pkg::RAW_W-1:0]         raw_sample,
	output logic signed [wsn_pkg::VAL_W-1:0]  sample_value,
	output logic                              invalid,
	output logic                              clipped
);

	logic        oob;

	logic        pcm_bad;
	logic [6:0]  pcm_rsh;
	logic [6:0]  pcm_top;
	logic [6:0]  pcm_lsh;
	logic [6:0]  pcm_rm1;
	logic [63:0] pcm_mask;
	logic [63:0] pcm_low;
	logic        pcm_neg;
	logic [63:0] pcm_abs;
	logic [63:0] pcm_t;
	logic [63:0] pcm_mag;

	logic        fl_is32;
	logic        fl_is64;
	logic        fl_special;
	logic        fl_neg;
	logic [52:0] fl_mant;
	logic [10:0] fl_exp;
	logic signed [12:0] fl_sh;
	logic [12:0] fl_rsh;
	logic [12:0] fl_rm1;
	logic [63:0] fl_t;
	logic [63:0] fl_mag;

	logic        fmt_bad;
	logic        use_tab;
	logic        neg;
	logic [63:0] mag;
	logic        sat;
	logic        can_clip;
	logic [31:0] mag_neg;
	logic [31:0] word;

	assign oob = (sample_index >= cfg.samp_count) || (channel >= cfg.chan_count);

	// Signed PCM: take the sign and magnitude of the low bits and scale to 31 fraction bits.
	always_comb begin
		pcm_bad  = !(cfg.bps inside {[7'd1:7'd64]});
		pcm_rsh  = 7'd64 - cfg.bps;
		pcm_top  = cfg.bps - 7'd1;
		pcm_lsh  = 7'd32 - cfg.bps;
		pcm_rm1  = cfg.bps - 7'd33;
		pcm_mask = ~64'd0 >> pcm_rsh[5:0];
		pcm_low  = raw_sample & pcm_mask;
		pcm_neg  = raw_sample[pcm_top[5:0]];
		pcm_abs  = pcm_neg ? ((~pcm_low + 64'd1) & pcm_mask) : pcm_low;
		pcm_t    = pcm_abs >> pcm_rm1[5:0];
		if (cfg.bps <= 7'd32) begin
			pcm_mag = pcm_abs << pcm_lsh[4:0];
		end else begin
			pcm_mag = (pcm_t >> 1) + {63'd0, pcm_t[0]};
		end
	end

	// IEEE float: the value is mant * 2^sh in units of 2^-31.
	always_comb begin
		fl_is32 = (cfg.bps == 7'd32);
		fl_is64 = (cfg.bps == 7'd64);
		if (fl_is64) begin
			fl_neg     = raw_sample[63];
			fl_exp     = raw_sample[62:52];
			fl_special = (fl_exp == 11'h7FF);
			fl_mant    = {fl_exp != 11'd0, raw_sample[51:0]};
			fl_sh      = $signed({2'b00, (fl_exp == 11'd0) ? 11'd1 : fl_exp}) - 13'sd1044;
		end else begin
			fl_neg     = raw_sample[31];
			fl_exp     = {3'd0, raw_sample[30:23]};
			fl_special = (fl_exp == 11'h0FF);
			fl_mant    = {29'd0, fl_exp != 11'd0, raw_sample[22:0]};
			fl_sh      = $signed({2'b00, (fl_exp == 11'd0) ? 11'd1 : fl_exp}) - 13'sd119;
		end
		fl_rsh = 13'd0 - fl_sh;
		fl_rm1 = fl_rsh - 13'd1;
		fl_t   = {11'd0, fl_mant} >> fl_rm1[5:0];
		if (fl_mant == 53'd0) begin
			fl_mag = '0;
		end else if (fl_sh >= 13'sd0) begin
			fl_mag = ~64'd0;
		end else if (fl_sh < -13'sd60) begin
			fl_mag = '0;
		end else begin
			fl_mag = (fl_t >> 1) + {63'd0, fl_t[0]};
		end
	end

	always_comb begin
		fmt_bad  = 1'b0;
		use_tab  = 1'b0;
		neg      = pcm_neg;
		mag      = pcm_mag;
		can_clip = 1'b0;
		case (cfg.format)
			wsn_pkg::FMT_PCM: begin
				fmt_bad = pcm_bad;
			end
			wsn_pkg::FMT_FLOAT: begin
				fmt_bad  = !(fl_is32 || fl_is64) || fl_special;
				neg      = fl_neg;
				mag      = fl_mag;
				can_clip = 1'b1;
			end
			wsn_pkg::FMT_MULAW, wsn_pkg::FMT_ALAW: begin
				use_tab = 1'b1;
			end
			default: begin
				fmt_bad = 1'b1;
			end
		endcase

		sat     = neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
		mag_neg = 32'd0 - mag[31:0];
		if (use_tab) begin
			word = (cfg.format == wsn_pkg::FMT_MULAW) ? wsn_pkg::MU_TAB[raw_sample[7:0]]
			                                          : wsn_pkg::A_TAB[raw_sample[7:0]];
		end else if (neg) begin
			word = sat ? wsn_pkg::Q31_NEG_MAX : mag_neg;
		end else begin
			word = sat ? wsn_pkg::Q31_POS_MAX : mag[31:0];
		end

		invalid      = oob || fmt_bad;
		sample_value = invalid ? '0 : $signed(word);
		clipped      = !invalid && can_clip && sat;
	end

endmodule

>>> sv/wav_sample_normalizer.sv
// ----------------------------------------------------------------------------
// Sample normalizer: decodes PCM, float and G.711 samples to Q1.31
// The decode runs between two registers: s1 holds the request, s2 the result.
// Throughput is one sample per cycle unless result.ready is low with s2 full.
// Reset clears both stage valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
`include "wav_sample_normalizer_assert.svh"

module wav_sample_normalizer (
	input  logic                            clk,
	input  logic                            arst_n,
	wsn_sample_if.sink                      sample,
	wsn_result_if.source                    result,
	input  logic                            wr_en,
	input  logic [wsn_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [wsn_pkg::CFG_DATA_W-1:0]  wr_data
);

	wsn_pkg::cfg_t cfg;

	logic                              valid_s1;
	logic [wsn_pkg::IDX_W-1:0]         sample_index_s1;
	logic [wsn_pkg::CH_W-1:0]          channel_s1;
	logic [wsn_pkg::RAW_W-1:0]         raw_s1;

	logic                              valid_s2;
	logic signed [wsn_pkg::VAL_W-1:0]  value_s2;
	logic                              invalid_s2;
	logic                              clipped_s2;

	logic signed [wsn_pkg::VAL_W-1:0]  dec_value;
	logic                              dec_invalid;
	logic                              dec_clipped;
	logic                              adv_s2;

	wsn_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	wsn_decode u_decode (
		.cfg          (cfg),
		.sample_index (sample_index_s1),
		.channel      (channel_s1),
		.raw_sample   (raw_s1),
		.sample_value (dec_value),
		.invalid      (dec_invalid),
		.clipped      (dec_clipped)
	);

	assign adv_s2       = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_index_s1 <= sample.sample_index;
			channel_s1      <= sample.channel;
			raw_s1          <= sample.raw_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			value_s2   <= dec_value;
			invalid_s2 <= dec_invalid;
			clipped_s2 <= dec_clipped;
		end
	end

	assign result.valid        = valid_s2;
	assign result.sample_value = value_s2;
	assign result.invalid      = invalid_s2;
	assign result.clipped      = clipped_s2;

	`WSN_ASSERT_NXT(a_transfer_fills_s1, sample.valid && sample.ready, valid_s1)
	`WSN_ASSERT_IMP(a_invalid_is_zero, valid_s2 && invalid_s2, value_s2 == '0 && !clipped_s2)
	`WSN_ASSERT_IMP(a_clip_on_rail, valid_s2 && clipped_s2, value_s2 == wsn_pkg::Q31_POS_MAX || value_s2 == wsn_pkg::Q31_NEG_MAX)
	`WSN_ASSERT_IMP(a_clip_only_float, valid_s2 && clipped_s2, cfg.format == wsn_pkg::FMT_FLOAT)

endmodule

>>> verif/tb_wav_sample_normalizer.sv
// ----------------------------------------------------------------------------
// Testbench for the sample normalizer
// Sends PCM, float and G.711 sample requests under several register settings,
// predicts each Q1.31 result with a bit-exact decoder, and checks every result
// transfer in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_wav_sample_normalizer;
	import wsn_pkg::*;

	localparam int unsigned IDLE_PCT        = 27;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned STALL_LIMIT     = 5000;
	localparam int unsigned RANDOM_PHASES   = 16;
	localparam int unsigned ITEMS_PER_PHASE = 38;
	localparam int unsigned TAIL_CYCLES     = 10;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam longint unsigned MU_SCALE    = 64'd8031;
	localparam longint unsigned A_SCALE     = 64'd4032;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             invalid;
		logic             clipped;
	} norm_t;

	class sample_scoreboard;
		logic [FMT_W-1:0] fmt;
		logic [BPS_W-1:0] bps;
		logic [CH_W-1:0]  chans;
		logic [IDX_W-1:0] samples;
		norm_t            expected_q[$];
		int unsigned      n_checked;
		int unsigned      n_errors;
		int unsigned      n_invalid;
		int unsigned      n_clipped;

		function new();
			fmt       = FMT_PCM;
			bps       = BPS_RESET;
			chans     = CHANNELS_RESET;
			samples   = '0;
			n_checked = 0;
			n_errors  = 0;
			n_invalid = 0;
			n_clipped = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_FORMAT:   fmt = data[FMT_W-1:0];
				REG_BPS:      bps = data[BPS_W-1:0];
				REG_CHANNELS: chans = data[CH_W-1:0];
				REG_SAMPLES:  samples = data[IDX_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [63:0] round_shift(logic [63:0] mag, int unsigned r);
			logic [63:0] q;
			q = mag >> r;
			if ((mag & ((64'd1 << r) - 64'd1)) >= (64'd1 << (r - 1))) begin
				q = q + 64'd1;
			end
			return q;
		endfunction

		function void to_q31(input bit neg, input logic [63:0] mag,
			output logic [VAL_W-1:0] word, output bit sat);
			logic [63:0] m;
			m = mag;
			sat = 1'b0;
			if (neg) begin
				if (m > 64'h8000_0000) begin
					sat = 1'b1;
					m = 64'h8000_0000;
				end
				word = 32'd0 - m[31:0];
			end else begin
				if (m > 64'h7FFF_FFFF) begin
					sat = 1'b1;
					m = 64'h7FFF_FFFF;
				end
				word = m[31:0];
			end
		endfunction

		function logic [63:0] g711_q31(logic [63:0] mag, logic [63:0] scale);
			return ((mag << 32) + scale) / (64'd2 * scale);
		endfunction

		function norm_t decode(logic [IDX_W-1:0] idx, logic [CH_W-1:0] ch,
			logic [RAW_W-1:0] raw);
			norm_t            res;
			logic [63:0]      mask;
			logic [63:0]      low;
			logic [63:0]      mag;
			logic [63:0]      mant;
			logic [7:0]       code;
			logic [2:0]       seg;
			logic [3:0]       frac;
			logic [VAL_W-1:0] word;
			int               sh;
			int unsigned      b;
			bit               neg;
			bit               sat;
			bit               bad;
			res = '0;
			bad = 1'b0;
			sat = 1'b0;
			neg = 1'b0;
			word = '0;
			mant = '0;
			sh = 0;
			b = bps;
			if (idx >= samples || ch >= chans) begin
				bad = 1'b1;
			end else begin
				case (fmt)
					FMT_PCM: begin
						if (b < 1 || b > 64) begin
							bad = 1'b1;
						end else begin
							mask = (b == 64) ? '1 : ((64'd1 << b) - 64'd1);
							low = raw & mask;
							neg = low[b-1];
							mag = neg ? ((~low + 64'd1) & mask) : low;
							if (neg && mag == 0) begin
								mag = 64'd1 << (b - 1);
							end
							if (b <= 32) begin
								mag = mag << (32 - b);
							end else begin
								mag = round_shift(mag, b - 32);
							end
							to_q31(neg, mag, word, sat);
						end
					end
					FMT_FLOAT: begin
						if (b == 32) begin
							neg = raw[31];
							sh = int'(raw[30:23]);
							mant = {41'd0, raw[22:0]};
							if (raw[30:23] == 8'hFF) begin
								bad = 1'b1;
							end
							if (sh != 0) begin
								mant[23] = 1'b1;
							end else begin
								sh = 1;
							end
							sh = sh - 119;
						end else if (b == 64) begin
							neg = raw[63];
							sh = int'(raw[62:52]);
							mant = {12'd0, raw[51:0]};
							if (raw[62:52] == 11'h7FF) begin
								bad = 1'b1;
							end
							if (sh != 0) begin
								mant[52] = 1'b1;
							end else begin
								sh = 1;
							end
							sh = sh - 1044;
						end else begin
							bad = 1'b1;
						end
						if (!bad) begin
							if (mant == 0) begin
								mag = '0;
							end else if (sh >= 0) begin
								mag = '1;
							end else if (sh < -60) begin
								mag = '0;
							end else begin
								mag = round_shift(mant, -sh);
							end
							to_q31(neg, mag, word, sat);
							res.clipped = sat;
						end
					end
					FMT_MULAW: begin
						code = ~raw[7:0];
						seg = code[6:4];
						frac = code[3:0];
						mag = ((((64'(frac) | 64'h10) << 1) | 64'd1) << seg) - 64'd33;
						to_q31(code[7], g711_q31(mag, MU_SCALE), word, sat);
					end
					default: begin
						code = raw[7:0] ^ 8'h55;
						seg = code[6:4];
						frac = code[3:0];
						mag = ((64'(frac) | ((seg != 0) ? 64'h10 : 64'h0)) << 1) | 64'd1;
						if (seg != 0) begin
							mag = mag << (seg - 1);
						end
						to_q31(!code[7], g711_q31(mag, A_SCALE), word, sat);
					end
				endcase
			end
			if (bad) begin
				res.value = '0;
				res.clipped = 1'b0;
			end else begin
				res.value = word;
			end
			res.invalid = bad;
			return res;
		endfunction

		function void note_sample(logic [IDX_W-1:0] idx, logic [CH_W-1:0] ch,
			logic [RAW_W-1:0] raw);
			norm_t res;
			res = decode(idx, ch, raw);
			if (res.invalid) n_invalid++;
			if (res.clipped) n_clipped++;
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [VAL_W-1:0] value, logic inv, logic clip);
			norm_t want;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS) begin
					$display("Unexpected result: value %h invalid %b clipped %b",
						value, inv, clip);
				end
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (value !== want.value || inv !== want.invalid || clip !== want.clipped) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS) begin
					$display("Mismatch on result %0d: expected %h/%b/%b, got %h/%b/%b",
						n_checked, want.value, want.invalid, want.clipped,
						value, inv, clip);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bit                    tx_steady;
	bit                    rx_steady;
	bit                    hold_request;
	int unsigned           stall_cycles;
	int unsigned           n_settings;
	int unsigned           n_sent;

	sample_scoreboard      sb = new();

	wsn_sample_if sample_ch();
	wsn_result_if result_ch();

	wav_sample_normalizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) begin
				sb.write_reg(wr_index, wr_data);
			end
			if (sample_ch.valid && sample_ch.ready) begin
				sb.note_sample(sample_ch.sample_index, sample_ch.channel, sample_ch.raw_sample);
				n_sent++;
			end
			if (result_ch.valid && result_ch.ready) begin
				sb.check_result(result_ch.sample_value, result_ch.invalid, result_ch.clipped);
			end
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
				$display("tb_wav_sample_normalizer: errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (rx_steady) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_sample(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] ch,
		input logic [RAW_W-1:0] raw);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_index <= idx;
		sample_ch.channel <= ch;
		sample_ch.raw_sample <= raw;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= data;
		@(negedge clk);
	endtask

	// The block is idle here, so the upper data bits carry noise the registers must drop.
	task automatic set_config(input logic [FMT_W-1:0] fmt, input logic [BPS_W-1:0] bps,
		input logic [CH_W-1:0] chans, input logic [IDX_W-1:0] samples);
		drain();
		write_reg(REG_FORMAT, {30'($urandom), fmt});
		write_reg(REG_BPS, {25'($urandom), bps});
		write_reg(REG_CHANNELS, {16'($urandom), chans});
		write_reg(REG_SAMPLES, samples);
		wr_en <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [RAW_W-1:0] random_raw(logic [FMT_W-1:0] fmt,
		logic [BPS_W-1:0] bps);
		logic [RAW_W-1:0] r;
		int unsigned      pick;
		r = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (fmt == FMT_FLOAT) begin
			if (bps == 64) begin
				if (pick < 70) r[62:52] = 11'(983 + $urandom_range(42));
				else if (pick < 80) r[62:52] = '1;
				else if (pick < 90) r[62:52] = '0;
			end else begin
				if (pick < 70) r[30:23] = 8'(87 + $urandom_range(42));
				else if (pick < 80) r[30:23] = '1;
				else if (pick < 90) r[30:23] = '0;
			end
		end else if (fmt == FMT_PCM && bps >= 1 && bps <= 64) begin
			if (pick < 4) r = '0;
			else if (pick < 8) r = '1;
			else if (pick < 12) r = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - bps);
			else if (pick < 16) r = 64'd1 << (bps - 1);
		end
		return r;
	endfunction

	initial begin
		logic [FMT_W-1:0] fmt;
		logic [BPS_W-1:0] bps;
		logic [CH_W-1:0]  chans;
		logic [IDX_W-1:0] samples;
		logic [IDX_W-1:0] idx;
		logic [CH_W-1:0]  ch;
		int unsigned      pick;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_index = '0;
		sample_ch.channel = '0;
		sample_ch.raw_sample = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_request = 1'b0;
		stall_cycles = 0;
		n_settings = 0;
		n_sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// After reset no frames are held, so every request is out of range.
		send_sample(0, 0, 64'h7FFF);

		set_config(FMT_PCM, 7'd16, 16'd4, 32'd100);
		send_sample(99, 3, 64'hDEAD_BEEF_0000_7FFF);
		send_sample(0, 0, 64'h1234_5678_9ABC_8000);
		send_sample(100, 0, 64'h1);
		send_sample(32'hFFFF_FFFF, 16'hFFFF, '1);

		set_config(FMT_PCM, 7'd1, 16'd1, 32'd1);
		send_sample(0, 0, 64'h1);
		send_sample(0, 0, 64'hFFFF_FFFF_FFFF_FFFE);

		set_config(FMT_PCM, 7'd64, 16'd1, 32'd1);
		send_sample(0, 0, 64'h8000_0000_0000_0000);
		send_sample(0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_sample(0, 0, 64'h0000_0000_8000_0000);

		set_config(FMT_PCM, 7'd0, 16'd1, 32'd1);
		send_sample(0, 0, 64'h5A5A);

		set_config(FMT_FLOAT, 7'd32, 16'd1, 32'd1);
		send_sample(0, 0, 64'h3F80_0000);
		send_sample(0, 0, 64'hFFFF_FFFF_BF80_0000);
		send_sample(0, 0, 64'h7FC0_0000);
		send_sample(0, 0, 64'hFF80_0000);
		send_sample(0, 0, 64'h8000_0000);
		send_sample(0, 0, 64'h0000_0001);
		send_sample(0, 0, 64'hC000_0000);

		set_config(FMT_FLOAT, 7'd64, 16'd1, 32'd1);
		send_sample(0, 0, 64'h3FF0_0000_0000_0000);
		send_sample(0, 0, 64'h7FF0_0000_0000_0000);
		send_sample(0, 0, 64'h0000_0000_0000_0001);

		set_config(FMT_FLOAT, 7'd16, 16'd1, 32'd1);
		send_sample(0, 0, 64'h3F80_0000);

		set_config(FMT_MULAW, 7'd8, 16'd1, 32'd1);
		send_sample(0, 0, 64'h00);
		send_sample(0, 0, 64'h80);
		send_sample(0, 0, 64'hFFFF_FFFF_FFFF_FFFF);

		set_config(FMT_ALAW, 7'd127, 16'd1, 32'd1);
		send_sample(0, 0, 64'h55);
		send_sample(0, 0, 64'hD5);
		send_sample(0, 0, 64'hFFFF_FF2A);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			fmt = FMT_W'(p % 4);
			pick = $urandom_range(99);
			case (fmt)
				FMT_PCM: begin
					if (p == 0) bps = 7'd64;
					else if (p == 4) bps = 7'd1;
					else if (pick < 90) bps = 7'($urandom_range(64, 1));
					else bps = 7'($urandom_range(127, 65));
				end
				FMT_FLOAT: bps = ((p / 4) % 2 == 0) ? 7'd32 : 7'd64;
				default: bps = 7'($urandom_range(127));
			endcase
			pick = $urandom_range(99);
			if (p == 0) chans = 16'hFFFF;
			else if (p == 1) chans = 16'd1;
			else if (pick < 5) chans = 16'd0;
			else if (pick < 45) chans = 16'($urandom_range(4, 1));
			else chans = 16'($urandom_range(65535, 1));
			pick = $urandom_range(99);
			if (p == 0) samples = 32'hFFFF_FFFF;
			else if (p == 1) samples = 32'd1;
			else if (pick < 5) samples = 32'd0;
			else if (pick < 50) samples = 32'($urandom_range(1000, 1));
			else samples = $urandom;

			set_config(fmt, bps, chans, samples);
			tx_steady = (p == 3);
			rx_steady = (p == 3);
			if (p == 2) hold_request = 1'b1;

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				if (pick < 85) begin
					idx = (samples == 0) ? $urandom : $urandom_range(samples - 1);
					ch = (chans == 0) ? 16'($urandom) : 16'($urandom_range(chans - 1));
				end else if (pick < 93) begin
					idx = samples + $urandom_range(3);
					ch = 16'($urandom);
				end else begin
					idx = $urandom;
					ch = chans + 16'($urandom_range(3));
				end
				send_sample(idx, ch, random_raw(fmt, bps));
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d sample requests across %0d register settings.", n_sent, n_settings);
		$display("Checked %0d results: %0d predicted invalid, %0d clipped, %0d mismatches.",
			sb.n_checked, sb.n_invalid, sb.n_clipped, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("tb_wav_sample_normalizer: clean");
		end else begin
			$display("tb_wav_sample_normalizer: errors");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/wsn_pkg.sv
sv/wsn_sample_if.sv
sv/wsn_result_if.sv
sv/wsn_cfg_regs.sv
sv/wsn_decode.sv
sv/wav_sample_normalizer.sv
verif/tb_wav_sample_normalizer.sv
